>>> rtl/core/lesf_pkg.sv
`timescale 1ns / 1ps

package lesf_pkg;

    localparam int MaxCols  = 1024;
    localparam int MaxRows  = 1024;
    localparam int ColW     = $clog2(MaxCols);
    localparam int RowW     = $clog2(MaxRows);
    localparam int SizeW    = 11;
    localparam int WidthW   = 11;
    localparam int CharW    = 8;
    localparam int CfgIdxW  = 1;
    localparam int CfgDataW = 11;

    localparam logic [WidthW-1:0] RowWidthReset = WidthW'(1024);
    localparam logic [CharW-1:0]  ObstacleReset = CharW'(111);
    localparam logic [RowW-1:0]   RowLast       = RowW'(MaxRows - 1);

    typedef enum logic [CfgIdxW-1:0] {
        REG_ROW_WIDTH = 1'b0,
        REG_OBSTACLE  = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic [CharW-1:0] cell_char;
        logic             is_last;
    } t_in_beat;

    typedef struct packed {
        logic [SizeW-1:0] square_size;
        logic [RowW-1:0]  top_row;
        logic [ColW-1:0]  left_col;
    } t_out_beat;

    // cell position and flags handed from the scan stage to the evaluate stage
    typedef struct packed {
        logic [ColW-1:0] col;
        logic [RowW-1:0] row;
        logic            blocked;
        logic            last;
        logic            fwd_hit;
    } t_scan_beat;

endpackage

>>> rtl/core/lesf_line_mem.sv
`timescale 1ns / 1ps

module lesf_line_mem
    import lesf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [ColW-1:0]  i_wr_addr,
    input  logic [SizeW-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [ColW-1:0]  i_rd_addr,
    output logic [SizeW-1:0] o_rd_data
);

    logic [SizeW-1:0] r_mem [MaxCols];
    logic [SizeW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read-before-write; same-edge collisions are forwarded by the caller
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/core/lesf_scan.sv
`timescale 1ns / 1ps

module lesf_scan
    import lesf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  t_in_beat          i_beat,
    input  logic [WidthW-1:0] i_row_width,
    input  logic [CharW-1:0]  i_obstacle,
    input  logic              i_advance,
    input  logic              i_wr_en,
    input  logic [ColW-1:0]   i_wr_addr,
    output logic [ColW-1:0]   o_rd_addr,
    output logic              o_valid,
    output t_scan_beat        o_beat
);

    logic [ColW-1:0]   r_col;
    logic [RowW-1:0]   r_row;
    logic [ColW-1:0]   n_col;
    logic [RowW-1:0]   n_row;
    logic              r_valid;
    t_scan_beat        r_beat;
    logic [WidthW-1:0] w_eff;
    logic              wrap_in;
    logic [ColW-1:0]   cur_col;
    logic [RowW-1:0]   cur_row;
    logic [RowW-1:0]   row_inc;
    logic [RowW-1:0]   cur_row_inc;
    logic [WidthW-1:0] col_plus;

    always_comb begin
        if (i_row_width == '0) begin
            w_eff = WidthW'(1);
        end else if (i_row_width > WidthW'(MaxCols)) begin
            w_eff = WidthW'(MaxCols);
        end else begin
            w_eff = i_row_width;
        end
    end

    assign row_inc     = (r_row == RowLast) ? r_row : r_row + RowW'(1);
    assign wrap_in     = WidthW'(r_col) >= w_eff;
    assign cur_col     = wrap_in ? '0 : r_col;
    assign cur_row     = wrap_in ? row_inc : r_row;
    assign cur_row_inc = (cur_row == RowLast) ? cur_row : cur_row + RowW'(1);
    assign col_plus    = WidthW'(cur_col) + WidthW'(1);

    always_comb begin
        if (i_beat.is_last) begin
            n_col = '0;
            n_row = '0;
        end else if (col_plus >= w_eff) begin
            n_col = '0;
            n_row = cur_row_inc;
        end else begin
            n_col = col_plus[ColW-1:0];
            n_row = cur_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_valid <= 1'b0;
        end else if (i_accept) begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_beat.col     <= cur_col;
            r_beat.row     <= cur_row;
            r_beat.blocked <= (i_beat.cell_char == i_obstacle);
            r_beat.last    <= i_beat.is_last;
            r_beat.fwd_hit <= i_wr_en && (i_wr_addr == cur_col);
        end
    end

    assign o_rd_addr = cur_col;
    assign o_valid   = r_valid;
    assign o_beat    = r_beat;

endmodule

>>> rtl/core/lesf_eval.sv
`timescale 1ns / 1ps

module lesf_eval
    import lesf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  t_scan_beat       i_beat,
    input  logic [SizeW-1:0] i_rd_data,
    input  logic             i_out_ready,
    output logic             o_advance,
    output logic             o_wr_en,
    output logic [ColW-1:0]  o_wr_addr,
    output logic [SizeW-1:0] o_wr_data,
    output logic             o_out_valid,
    output t_out_beat        o_out_data
);

    logic [SizeW-1:0] r_left;
    logic [SizeW-1:0] r_diag;
    logic [SizeW-1:0] r_fwd;
    logic [SizeW-1:0] r_best_size;
    logic [RowW-1:0]  r_best_row;
    logic [ColW-1:0]  r_best_col;
    logic             r_out_valid;
    t_out_beat        r_out;

    logic [SizeW-1:0] up_mem;
    logic [SizeW-1:0] up;
    logic [SizeW-1:0] left;
    logic [SizeW-1:0] diag;
    logic [SizeW-1:0] m01;
    logic [SizeW-1:0] m012;
    logic [SizeW-1:0] row_cap;
    logic [SizeW-1:0] col_cap;
    logic [SizeW-1:0] s_a;
    logic [SizeW-1:0] s_b;
    logic [SizeW-1:0] s;
    logic             better;
    logic [SizeW-1:0] row_top;
    logic [SizeW-1:0] col_left;
    t_out_beat        best;

    // a last cell waits only while the result register holds a beat not taken now
    assign o_advance = i_valid && !(i_beat.last && r_out_valid && !i_out_ready);

    assign up_mem = i_beat.fwd_hit ? r_fwd : i_rd_data;
    assign up     = (i_beat.row == '0) ? '0 : up_mem;
    assign left   = (i_beat.col == '0) ? '0 : r_left;
    assign diag   = (i_beat.col == '0) ? '0 : r_diag;

    assign m01     = (up < left) ? up : left;
    assign m012    = (m01 < diag) ? m01 : diag;
    assign row_cap = SizeW'(i_beat.row) + SizeW'(1);
    assign col_cap = SizeW'(i_beat.col) + SizeW'(1);
    assign s_a     = m012 + SizeW'(1);
    assign s_b     = (s_a > row_cap) ? row_cap : s_a;
    assign s       = i_beat.blocked ? '0 : ((s_b > col_cap) ? col_cap : s_b);

    assign better   = s > r_best_size;
    assign row_top  = row_cap - s;
    assign col_left = col_cap - s;

    always_comb begin
        if (better) begin
            best.square_size = s;
            best.top_row     = row_top[RowW-1:0];
            best.left_col    = col_left[ColW-1:0];
        end else begin
            best.square_size = r_best_size;
            best.top_row     = r_best_row;
            best.left_col    = r_best_col;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_size <= '0;
            r_best_row  <= '0;
            r_best_col  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_advance) begin
                if (i_beat.last) begin
                    r_best_size <= '0;
                    r_best_row  <= '0;
                    r_best_col  <= '0;
                end else begin
                    r_best_size <= best.square_size;
                    r_best_row  <= best.top_row;
                    r_best_col  <= best.left_col;
                end
            end
            if (o_advance && i_beat.last) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance) begin
            r_left <= s;
            r_diag <= up;
            r_fwd  <= s;
            if (i_beat.last) begin
                r_out <= best;
            end
        end
    end

    assign o_wr_en     = o_advance;
    assign o_wr_addr   = i_beat.col;
    assign o_wr_data   = s;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> rtl/core/largest_empty_square_finder.sv
`timescale 1ns / 1ps

// Largest empty square finder. Grid cells stream in raster order, one
// character per beat, row_width cells to a row; a cell whose character equals
// obstacle_char is blocked. For each cell the block forms the side of the
// largest empty square ending there (0 if blocked, else one more than the
// smallest of the up, left and up-left sizes) and keeps the largest, first
// found winning ties. The beat flagged is_last yields one result beat with
// the size and the top-left row and column (counted from 0; all zero when
// there is no empty cell) and starts a new grid. Throughput is one cell per
// clock unless the input stalls: the scan stage tracks row and column and
// issues the line-store read, the evaluate stage gets the previous row's size
// in the cycle after the read, applies the min-of-three step and writes back,
// with same-address read/write collisions forwarded. A result beat is
// registered as its last cell leaves the evaluate stage. Input stalls only
// while a last cell waits behind a result beat that is not taken in that
// cycle. Row width 0 acts as 1 and widths above 1024 saturate; row count
// saturates at 1023. Configuration is to be written only while the block is
// idle, which the block does not enforce; the line store needs no clearing.

module largest_empty_square_finder
    import lesf_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  t_in_beat            i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output t_out_beat           o_out_data,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_idx,
    input  logic [CfgDataW-1:0] i_cfg_data
);

    logic [WidthW-1:0] r_row_width;
    logic [CharW-1:0]  r_obstacle;

    logic              accept;
    logic              s1_valid;
    t_scan_beat        s1_beat;
    logic              advance;
    logic [ColW-1:0]   rd_addr;
    logic [SizeW-1:0]  rd_data;
    logic              wr_en;
    logic [ColW-1:0]   wr_addr;
    logic [SizeW-1:0]  wr_data;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_width <= RowWidthReset;
            r_obstacle  <= ObstacleReset;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                REG_ROW_WIDTH: begin
                    r_row_width <= i_cfg_data[WidthW-1:0];
                end
                REG_OBSTACLE: begin
                    r_obstacle <= i_cfg_data[CharW-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // evaluate stage either empty or moving on frees the scan stage
    assign o_in_ready = advance || !s1_valid;
    assign accept     = i_in_valid && o_in_ready;

    lesf_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_beat      (i_in_data),
        .i_row_width (r_row_width),
        .i_obstacle  (r_obstacle),
        .i_advance   (advance),
        .i_wr_en     (wr_en),
        .i_wr_addr   (wr_addr),
        .o_rd_addr   (rd_addr),
        .o_valid     (s1_valid),
        .o_beat      (s1_beat)
    );

    // read only on accept so the data holds while a last beat waits
    lesf_line_mem u_line_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (accept),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    lesf_eval u_eval (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s1_valid),
        .i_beat      (s1_beat),
        .i_rd_data   (rd_data),
        .i_out_ready (i_out_ready),
        .o_advance   (advance),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    // a result beat only follows a last cell leaving the evaluate stage
    a_out_from_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(advance && s1_beat.last))
        else $error("result beat without a last cell");

    // an empty result reports the origin
    a_empty_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.square_size == '0) |->
            (o_out_data.top_row == '0 && o_out_data.left_col == '0))
        else $error("empty result with nonzero corner");

    // square must fit inside the row range
    a_square_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            ((SizeW + 1)'(o_out_data.square_size) + (SizeW + 1)'(o_out_data.top_row)
                <= (SizeW + 1)'(MaxRows)))
        else $error("square extends past the grid");

    // scan stage never loses a beat: accept with a full stage only if it moves on
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && s1_valid) |-> advance)
        else $error("scan stage overrun");

endmodule
